>>> design/srt_pkg.sv
// Shared operation codes, status codes, widths and cell command type for the sorted record table.
package srt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INS_SORT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE_AT = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_AT  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_KEY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [1:0] MODE_KEEP   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] score;
    logic [1:0]        mode;
  } cell_cmd_t;

endpackage

>>> design/srt_cell.sv
// One table slot: holds a record, flags a match for the scan, and shifts with its neighbors.
module srt_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                       clk,
  input  srt_pkg::cell_cmd_t         cmd,
  input  logic [PW-1:0]              pos,
  input  logic [PW-1:0]              count,
  input  logic                       hot,
  input  logic                       incl,
  input  logic [srt_pkg::DATA_W-1:0] left_key,
  input  logic [srt_pkg::DATA_W-1:0] left_score,
  input  logic [srt_pkg::DATA_W-1:0] right_key,
  input  logic [srt_pkg::DATA_W-1:0] right_score,
  output logic                       flag,
  output logic [srt_pkg::DATA_W-1:0] key,
  output logic [srt_pkg::DATA_W-1:0] score
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [srt_pkg::DATA_W-1:0] key_r;
  logic [srt_pkg::DATA_W-1:0] score_r;
  logic [srt_pkg::DATA_W-1:0] key_nxt;
  logic [srt_pkg::DATA_W-1:0] score_nxt;
  logic                       live;

  assign live  = MY_IDX < count;
  assign key   = key_r;
  assign score = score_r;

  always_comb begin
    unique case (cmd.op)
      srt_pkg::OP_INS_SORT:
        flag = (live && ($signed(key_r) > $signed(cmd.key))) || (MY_IDX == count);
      srt_pkg::OP_FIND_KEY:
        flag = live && (key_r == cmd.key);
      srt_pkg::OP_INS_AT, srt_pkg::OP_ERASE_AT, srt_pkg::OP_READ_AT:
        flag = (MY_IDX == pos);
      default:
        flag = 1'b0;
    endcase
  end

  always_comb begin
    key_nxt   = key_r;
    score_nxt = score_r;
    unique case (cmd.mode)
      srt_pkg::MODE_INSERT: begin
        if (hot) begin
          key_nxt   = cmd.key;
          score_nxt = cmd.score;
        end else if (incl) begin
          key_nxt   = left_key;
          score_nxt = left_score;
        end
      end
      srt_pkg::MODE_ERASE: begin
        if (incl) begin
          key_nxt   = right_key;
          score_nxt = right_score;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    score_r <= score_nxt;
  end

endmodule

>>> design/srt_scan.sv
// Priority scan over the cell flags: inclusive prefix mask and the one-hot first hit.
module srt_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] flags,
  output logic [N-1:0] incl,
  output logic [N-1:0] hot
);

  localparam int STAGES = $clog2(N);

  logic [N-1:0] acc;

  always_comb begin
    acc = flags;
    for (int s = 0; s < STAGES; s++) begin
      acc = acc | (acc << (1 << s));
    end
    incl = acc;
    hot  = acc & ~(acc << 1);
  end

endmodule

>>> design/sorted_record_table.sv
// Sorted record table: ordered key/score records kept in a row of shifting cells.
//
// Input channel (in_*): one operation per transfer (insert sorted, insert at,
// erase at, read at, find key). Result channel (out_*): exactly one result per
// operation, with status, position, record and the entry count afterwards.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Each operation runs a scan step and then a commit step after the input
// transfer. Scan: every cell compares its record, and a priority scan picks
// the first hit. Commit: all cells shift or load together and the result
// register loads. The input stalls for the whole operation; a stalled
// result holds the commit step off.
// Reset clears the entry count and the handshake state; cell
// contents are not cleared and read as nothing until written.
// While a result waits with out_stall high it holds and no new result is produced;
// the next operation may be taken while a finished result waits.
module sorted_record_table #(
  parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srt_pkg::OP_W-1:0]     in_operation,
  input  logic [srt_pkg::POS_W-1:0]    in_position,
  input  logic signed [srt_pkg::DATA_W-1:0] in_key_in,
  input  logic signed [srt_pkg::DATA_W-1:0] in_score_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [srt_pkg::STATUS_W-1:0] out_status,
  output logic [srt_pkg::FPOS_W-1:0]   out_found_position,
  output logic signed [srt_pkg::DATA_W-1:0] out_key_out,
  output logic signed [srt_pkg::DATA_W-1:0] out_score_out,
  output logic [srt_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int PW  = (CW > srt_pkg::POS_W) ? CW : srt_pkg::POS_W;
  localparam int XW  = (IW > srt_pkg::FPOS_W) ? IW : srt_pkg::FPOS_W;
  localparam int CXW = (CW > srt_pkg::COUNT_W) ? CW : srt_pkg::COUNT_W;
  localparam int DW  = srt_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [1:0]                 state_r, state_nxt;
  logic [srt_pkg::OP_W-1:0]   op_r;
  logic [srt_pkg::POS_W-1:0]  pos_r;
  logic [DW-1:0]              key_r;
  logic [DW-1:0]              score_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CAPACITY-1:0]        hot_r, incl_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [srt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [srt_pkg::FPOS_W-1:0] fpos_r, fpos_nxt;
  logic [DW-1:0]              kout_r, kout_nxt;
  logic [DW-1:0]              sout_r, sout_nxt;

  logic [CAPACITY-1:0]        flags, scan_incl, scan_hot;
  logic [DW-1:0]              cell_key [CAPACITY];
  logic [DW-1:0]              cell_score [CAPACITY];
  srt_pkg::cell_cmd_t         cmd;
  logic [PW-1:0]              pos_p, count_p;

  logic                       in_xfer, commit, is_full, any_hit;
  logic [DW-1:0]              sel_key, sel_score;
  logic [IW-1:0]              sel_idx;
  logic [XW-1:0]              sel_idx_x;
  logic [CXW-1:0]             count_x;
  logic [1:0]                 mode;

  assign in_stall  = state_r != S_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign pos_p     = PW'(pos_r);
  assign count_p   = PW'(count_r);
  assign is_full   = count_p >= CAP_P;
  assign any_hit   = |hot_r;
  assign sel_idx_x = XW'(sel_idx);
  assign count_x   = CXW'(count_r);

  assign cmd.op    = op_r;
  assign cmd.key   = key_r;
  assign cmd.score = score_r;
  assign cmd.mode  = mode;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] lk, ls, rk, rs;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign ls = '0;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign ls = cell_score[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rs = '0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rs = cell_score[i+1];
    end
    srt_cell #(.IDX(i), .PW(PW)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos_p),
      .count       (count_p),
      .hot         (hot_r[i]),
      .incl        (incl_r[i]),
      .left_key    (lk),
      .left_score  (ls),
      .right_key   (rk),
      .right_score (rs),
      .flag        (flags[i]),
      .key         (cell_key[i]),
      .score       (cell_score[i])
    );
  end

  srt_scan #(.N(CAPACITY)) u_scan (
    .flags (flags),
    .incl  (scan_incl),
    .hot   (scan_hot)
  );

  always_comb begin
    sel_key   = '0;
    sel_score = '0;
    sel_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hot_r[i]) begin
        sel_key   = sel_key | cell_key[i];
        sel_score = sel_score | cell_score[i];
        sel_idx   = sel_idx | IW'(i);
      end
    end
  end

  always_comb begin
    mode       = srt_pkg::MODE_KEEP;
    count_nxt  = count_r;
    status_nxt = status_r;
    fpos_nxt   = fpos_r;
    kout_nxt   = kout_r;
    sout_nxt   = sout_r;
    if (commit) begin
      status_nxt = srt_pkg::ST_OK;
      fpos_nxt   = '0;
      kout_nxt   = '0;
      sout_nxt   = '0;
      unique case (op_r)
        srt_pkg::OP_INS_SORT, srt_pkg::OP_INS_AT: begin
          if (is_full) begin
            status_nxt = srt_pkg::ST_FULL;
          end else if ((op_r == srt_pkg::OP_INS_AT) && (pos_p > count_p)) begin
            status_nxt = srt_pkg::ST_RANGE;
          end else begin
            mode      = srt_pkg::MODE_INSERT;
            count_nxt = count_r + CW'(1);
            fpos_nxt  = sel_idx_x[srt_pkg::FPOS_W-1:0];
            kout_nxt  = key_r;
            sout_nxt  = score_r;
          end
        end
        srt_pkg::OP_ERASE_AT, srt_pkg::OP_READ_AT: begin
          if (pos_p >= count_p) begin
            status_nxt = srt_pkg::ST_RANGE;
          end else begin
            fpos_nxt = sel_idx_x[srt_pkg::FPOS_W-1:0];
            kout_nxt = sel_key;
            sout_nxt = sel_score;
            if (op_r == srt_pkg::OP_ERASE_AT) begin
              mode      = srt_pkg::MODE_ERASE;
              count_nxt = count_r - CW'(1);
            end
          end
        end
        srt_pkg::OP_FIND_KEY: begin
          if (any_hit) begin
            fpos_nxt = sel_idx_x[srt_pkg::FPOS_W-1:0];
            kout_nxt = sel_key;
            sout_nxt = sel_score;
          end else begin
            status_nxt = srt_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_SCAN;
      S_SCAN: state_nxt = S_EXEC;
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_operation;
      pos_r   <= in_position;
      key_r   <= in_key_in;
      score_r <= in_score_in;
    end
    if (state_r == S_SCAN) begin
      hot_r  <= scan_hot;
      incl_r <= scan_incl;
    end
    status_r <= status_nxt;
    fpos_r   <= fpos_nxt;
    kout_r   <= kout_nxt;
    sout_r   <= sout_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = fpos_r;
  assign out_key_out        = kout_r;
  assign out_score_out      = sout_r;
  assign out_entry_count    = count_x[srt_pkg::COUNT_W-1:0];

endmodule

>>> design/srt_checker.sv
// Port-level checks for the sorted record table, bound to the top level.
module srt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [srt_pkg::STATUS_W-1:0] out_status,
  input logic [srt_pkg::FPOS_W-1:0]   out_found_position,
  input logic [srt_pkg::DATA_W-1:0]   out_key_out,
  input logic [srt_pkg::DATA_W-1:0]   out_score_out
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after transfer");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != srt_pkg::ST_OK) |->
      (out_found_position == '0) && (out_key_out == '0) && (out_score_out == '0))
    else $error("failed operation carries nonzero record");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_out) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_found_position (out_found_position),
  .out_key_out        (out_key_out),
  .out_score_out      (out_score_out)
);

>>> tb/testbench.sv
// Self-checking testbench for the sorted record table: directed and random table operations.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIX    = 2;

  localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FPOS_W-1:0]   position;
    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   score;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_operation;
  logic [POS_W-1:0]           in_position;
  logic signed [DATA_W-1:0]   in_key_in;
  logic signed [DATA_W-1:0]   in_score_in;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        out_status;
  logic [FPOS_W-1:0]          out_found_position;
  logic signed [DATA_W-1:0]   out_key_out;
  logic signed [DATA_W-1:0]   out_score_out;
  logic [COUNT_W-1:0]         out_entry_count;

  logic [DATA_W-1:0] model_keys [DEPTH];
  logic [DATA_W-1:0] model_scores [DEPTH];
  int                model_count;

  table_result_t pending_results [$];
  int errors;
  int checked;
  int cycle_count;
  int op_tally [8];
  int full_seen;
  int range_seen;
  int missing_seen;

  sorted_record_table #(.CAPACITY(DEPTH)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_key_in          (in_key_in),
    .in_score_in        (in_score_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_score_out      (out_score_out),
    .out_entry_count    (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall in phases of differing density
  initial begin
    int mode;
    int span;
    int run;
    int tick;
    bit hold;
    out_stall = 1'b0;
    run = 0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: hold = 1'b0;
          1: hold = ($urandom_range(0, 99) < 30);
          2: hold = ($urandom_range(0, 99) < 75);
          default: hold = ((tick % 9) < 4);
        endcase
        if (run >= 12) hold = 1'b0;
        run = hold ? run + 1 : 0;
        out_stall <= hold;
      end
    end
  end

  function automatic void place_record(input int slot, input logic [DATA_W-1:0] key,
                                       input logic [DATA_W-1:0] score);
    for (int i = model_count; i > slot; i--) begin
      model_keys[i]   = model_keys[i-1];
      model_scores[i] = model_scores[i-1];
    end
    model_keys[slot]   = key;
    model_scores[slot] = score;
    model_count++;
  endfunction

  function automatic void table_apply(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] key,
                                      input logic [DATA_W-1:0] score,
                                      output table_result_t r);
    int slot;
    r = '0;
    slot = model_count;
    case (op)
      OP_INS_SORT, OP_INS_AT: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_INS_AT && int'(pos) > model_count) begin
          r.status = ST_RANGE;
        end else begin
          if (op == OP_INS_AT) begin
            slot = int'(pos);
          end else begin
            for (int i = model_count - 1; i >= 0; i--)
              if ($signed(model_keys[i]) > $signed(key)) slot = i;
          end
          place_record(slot, key, score);
          r.position = slot[FPOS_W-1:0];
          r.key      = key;
          r.score    = score;
        end
      end
      OP_ERASE_AT, OP_READ_AT: begin
        if (int'(pos) >= model_count) begin
          r.status = ST_RANGE;
        end else begin
          r.position = pos[FPOS_W-1:0];
          r.key      = model_keys[pos];
          r.score    = model_scores[pos];
          if (op == OP_ERASE_AT) begin
            for (int i = int'(pos); i < model_count - 1; i++) begin
              model_keys[i]   = model_keys[i+1];
              model_scores[i] = model_scores[i+1];
            end
            model_count--;
          end
        end
      end
      OP_FIND_KEY: begin
        r.status = ST_NOT_FOUND;
        for (int i = model_count - 1; i >= 0; i--) begin
          if (model_keys[i] == key) begin
            r.status   = ST_OK;
            r.position = i[FPOS_W-1:0];
            r.key      = model_keys[i];
            r.score    = model_scores[i];
          end
        end
      end
      default: ;
    endcase
    r.count = model_count[COUNT_W-1:0];
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] score);
    table_result_t want;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_key_in    <= key;
    in_score_in  <= score;
    do @(posedge clk); while (in_stall);
    table_apply(op, pos, key, score, want);
    pending_results = {pending_results, want};
    op_tally[op]++;
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      case (out_status)
        ST_FULL:      full_seen++;
        ST_RANGE:     range_seen++;
        ST_NOT_FOUND: missing_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d, key %h", out_status, out_key_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_found_position !== want.position) begin
          $error("found_position: expected %0d, got %0d", want.position, out_found_position);
          errors++;
        end
        if (out_key_out !== want.key) begin
          $error("key_out: expected %h, got %h", want.key, out_key_out);
          errors++;
        end
        if (out_score_out !== want.score) begin
          $error("score_out: expected %h, got %h", want.score, out_score_out);
          errors++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_op(OP_READ_AT, 7'd0, '0, '0);
    send_op(OP_ERASE_AT, 7'd0, '0, '0);
    send_op(OP_FIND_KEY, 7'd0, '0, '0);
    send_op(OP_INS_AT, 7'd1, KEY_MAX, ALL_ONES);
    send_op(OP_INS_AT, 7'h7F, KEY_MIN, ALL_ONES);
    for (int k = 1; k <= 3; k++)
      send_op(OP_FIND_KEY + k[OP_W-1:0], 7'h7F, ALL_ONES, ALL_ONES);
    idle_for(3);
  endtask

  task automatic test_each_operation();
    send_op(OP_INS_SORT, 7'd0, 32'd0, 32'd1);
    send_op(OP_INS_SORT, 7'd0, KEY_MAX, ALL_ONES);
    send_op(OP_INS_SORT, 7'd0, KEY_MIN, KEY_MIN);
    send_op(OP_INS_SORT, 7'h7F, 32'd0, 32'd2);
    send_op(OP_INS_SORT, 7'd0, ALL_ONES, KEY_MAX);
    send_op(OP_INS_AT, 7'd5, 32'd5, 32'h0000_0005);
    send_op(OP_INS_AT, 7'd0, 32'd7, 32'hAAAA_AAAA);
    send_op(OP_INS_AT, 7'd3, 32'h5555_5555, 32'h5555_5555);
    send_op(OP_READ_AT, 7'd0, '0, '0);
    send_op(OP_READ_AT, 7'd7, '0, '0);
    send_op(OP_READ_AT, 7'd8, '0, '0);
    send_op(OP_FIND_KEY, 7'd0, 32'd0, '0);
    send_op(OP_FIND_KEY, 7'd0, 32'd12345, '0);
    send_op(OP_FIND_KEY, 7'd0, KEY_MAX, '0);
    send_op(OP_ERASE_AT, 7'd0, '0, '0);
    send_op(OP_ERASE_AT, 7'd6, '0, '0);
    send_op(OP_ERASE_AT, 7'd2, '0, '0);
    send_op(OP_ERASE_AT, 7'd64, '0, '0);
    idle_for(2);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 97) return OP_FIND_KEY + OP_W'($urandom_range(1, 3));
    case (phase)
      PH_GROW:
        return r < 45 ? OP_INS_SORT : r < 78 ? OP_INS_AT : r < 85 ? OP_READ_AT :
               r < 92 ? OP_FIND_KEY : OP_ERASE_AT;
      PH_SHRINK:
        return r < 68 ? OP_ERASE_AT : r < 74 ? OP_INS_SORT : r < 78 ? OP_INS_AT :
               r < 87 ? OP_READ_AT : OP_FIND_KEY;
      default:
        return r < 25 ? OP_INS_SORT : r < 42 ? OP_INS_AT : r < 62 ? OP_ERASE_AT :
               r < 78 ? OP_READ_AT : OP_FIND_KEY;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    if ($urandom_range(0, 99) < 15 ||
        !(op == OP_INS_AT || op == OP_ERASE_AT || op == OP_READ_AT))
      return POS_W'($urandom_range(0, 127));
    if (op == OP_INS_AT) return POS_W'($urandom_range(0, model_count));
    if (model_count == 0) return '0;
    return POS_W'($urandom_range(0, model_count - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 7))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 32'd0;
        3: return ALL_ONES;
        4: return 32'd1;
        5: return 32'hFFFF_FFFE;
        6: return 32'd100;
        default: return 32'h8000_0001;
      endcase
    end
    if (r < 60 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    return $urandom();
  endfunction

  task automatic test_random_mix(input int total);
    int done;
    int phase;
    int phase_left;
    int burst_left;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    done = 0;
    phase = PH_MIX;
    phase_left = 0;
    burst_left = 0;
    while (done < total) begin
      if (phase_left == 0) begin
        phase = (phase + 1) % 3;
        phase_left = $urandom_range(90, 170);
      end
      if (burst_left == 0) begin
        idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 24);
      end
      op  = pick_op(phase);
      pos = pick_position(op);
      send_op(op, pos, pick_key(), $urandom());
      done++;
      phase_left--;
      burst_left--;
    end
    idle_for(1);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_position  = '0;
    in_key_in    = '0;
    in_score_in  = '0;
    errors       = 0;
    checked      = 0;
    cycle_count  = 0;
    model_count  = 0;
    full_seen    = 0;
    range_seen   = 0;
    missing_seen = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_each_operation();
    test_random_mix(RANDOM_ITEMS);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sorted inserts, %0d positional inserts, %0d erases, %0d reads, %0d finds, %0d spare codes",
             op_tally[OP_INS_SORT], op_tally[OP_INS_AT], op_tally[OP_ERASE_AT],
             op_tally[OP_READ_AT], op_tally[OP_FIND_KEY],
             op_tally[5] + op_tally[6] + op_tally[7]);
    $display("Checked %0d results: %0d full-table, %0d out-of-range, %0d key-missing rejections",
             checked, full_seen, range_seen, missing_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
